/* rtl/fix_tag_value_tokenizer_defines.svh */
// ----------------------------------------------------------------------------
// FIX tag=value tokenizer: assertion macros
// Shared property shapes for the tokenizer's checks, clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIX_TAG_VALUE_TOKENIZER_DEFINES_SVH
`define FIX_TAG_VALUE_TOKENIZER_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons must hold as well.
`define FXTOK_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fxtok: implication check failed");

// Next-cycle implication: ante in one cycle requires cons in the following one.
`define FXTOK_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fxtok: next-cycle check failed");

`endif

/* rtl/fxtok_pkg.sv */
// ----------------------------------------------------------------------------
// fxtok_pkg
// Types, character codes and register indexes shared by the tokenizer files.
// ----------------------------------------------------------------------------
`default_nettype none

package fxtok_pkg;

	localparam int TAG_W    = 20;
	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 8;
	localparam int SLOT_W   = 3;
	localparam int ERR_W    = 3;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 20;

	localparam logic [BYTE_W-1:0] SOH_CHAR = 8'h01;
	localparam logic [BYTE_W-1:0] SEP_CHAR = 8'h3D;
	localparam logic [BYTE_W-1:0] DIGIT0   = 8'h30;
	localparam logic [TAG_W-1:0]  TAG_MAX  = 20'd999999;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PASS_MODE   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TAG_SLOT0   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_ENABLE = 4'd7;

	// error codes
	localparam logic [ERR_W-1:0] ERR_OK       = 3'd0;
	localparam logic [ERR_W-1:0] ERR_NONDIGIT = 3'd1;
	localparam logic [ERR_W-1:0] ERR_TAG_OVF  = 3'd2;
	localparam logic [ERR_W-1:0] ERR_LEN_SAT  = 3'd3;
	localparam logic [ERR_W-1:0] ERR_IN_TAG   = 3'd4;

	// result kinds
	localparam logic KIND_VALUE = 1'b0;
	localparam logic KIND_END   = 1'b1;

	// output queue
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = 2;
	localparam int OQ_CNT_W = 3;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_TAG   = 2'd1,
		PH_VALUE = 2'd2
	} phase_t;

	typedef struct packed {
		logic              kind;
		logic [TAG_W-1:0]  tag;
		logic [BYTE_W-1:0] vbyte;
		logic [LEN_W-1:0]  vlen;
		logic              registered;
		logic [SLOT_W-1:0] slot;
		logic [ERR_W-1:0]  err;
		logic              msg_end;
		logic              last;
	} res_t;

	// results produced by one byte, first one in r0
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

	function automatic res_t mk_res(input logic kind, input logic [TAG_W-1:0] tag,
			input logic [BYTE_W-1:0] vbyte, input logic [LEN_W-1:0] vlen,
			input logic registered, input logic [SLOT_W-1:0] slot,
			input logic [ERR_W-1:0] err, input logic msg_end);
		res_t r;
		r.kind       = kind;
		r.tag        = tag;
		r.vbyte      = vbyte;
		r.vlen       = vlen;
		r.registered = registered;
		r.slot       = slot;
		r.err        = err;
		r.msg_end    = msg_end;
		r.last       = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/fxtok_cfg.sv */
// ----------------------------------------------------------------------------
// fxtok_cfg
// Configuration registers: pass mode, tag slots and slot enables.
// ----------------------------------------------------------------------------
`default_nettype none

module fxtok_cfg #(
	parameter int TAG_SLOTS = 6
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               wr_en,
	input  wire logic [fxtok_pkg::CFG_IDX_W-1:0]    wr_index,
	input  wire logic [fxtok_pkg::CFG_DATA_W-1:0]   wr_data,
	output logic                                    pass_mode,
	output logic [fxtok_pkg::TAG_W-1:0]             slot_tag [TAG_SLOTS],
	output logic [TAG_SLOTS-1:0]                    slot_en
);
	import fxtok_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_mode <= 1'b0;
			slot_en   <= '0;
			for (int i = 0; i < TAG_SLOTS; i++) begin
				slot_tag[i] <= '0;
			end
		end else if (wr_en) begin
			if (wr_index == CFG_PASS_MODE) begin
				pass_mode <= wr_data[0];
			end
			if (wr_index == CFG_SLOT_ENABLE) begin
				slot_en <= wr_data[TAG_SLOTS-1:0];
			end
			for (int i = 0; i < TAG_SLOTS; i++) begin
				if (wr_index == CFG_IDX_W'(CFG_TAG_SLOT0 + CFG_IDX_W'(i))) begin
					slot_tag[i] <= wr_data[TAG_W-1:0];
				end
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/fxtok_parse.sv */
// ----------------------------------------------------------------------------
// fxtok_parse
// Input register and per-byte parser: tag build, match, value count, results.
// ----------------------------------------------------------------------------
`default_nettype none

module fxtok_parse #(
	parameter int TAG_SLOTS     = 6,
	parameter int MAX_VALUE_LEN = 255
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [fxtok_pkg::BYTE_W-1:0]   in_byte,
	input  wire logic                           in_last,
	input  wire logic                           pass_mode,
	input  wire logic [fxtok_pkg::TAG_W-1:0]    slot_tag [TAG_SLOTS],
	input  wire logic [TAG_SLOTS-1:0]           slot_en,
	input  wire logic                           room,
	output fxtok_pkg::push_t                    push
);
	import fxtok_pkg::*;

	localparam int CNT_W = $clog2(MAX_VALUE_LEN + 1);
	localparam int EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam int MUL_W = TAG_W + 4;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;
	logic              adv;

	phase_t            phase_q, phase_n;
	logic [TAG_W-1:0]  acc_q, acc_n;
	logic [CNT_W-1:0]  cnt_q, cnt_n;
	logic              hit_q, hit_n;
	logic [SLOT_W-1:0] slot_q, slot_n;
	logic [ERR_W-1:0]  err_q, err_n;

	logic              at_start;
	phase_t            eff_phase;
	logic [TAG_W-1:0]  acc_e;
	logic [CNT_W-1:0]  cnt_e;
	logic              hit_e;
	logic [SLOT_W-1:0] slot_e;
	logic [ERR_W-1:0]  err_e;

	logic              is_soh, is_sep, is_digit;
	logic [MUL_W-1:0]  prod;
	logic [TAG_W-1:0]  acc_t;
	logic [ERR_W-1:0]  err_t;
	logic              m_hit;
	logic [SLOT_W-1:0] m_slot;
	logic [EXT_W-1:0]  cnt_ext;
	logic [LEN_W-1:0]  len_n;
	logic              clear;
	push_t             push_c;

	assign adv      = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			acc_q   <= '0;
			cnt_q   <= '0;
			hit_q   <= 1'b0;
			slot_q  <= '0;
			err_q   <= ERR_OK;
		end else if (adv) begin
			phase_q <= phase_n;
			acc_q   <= clear ? '0 : acc_n;
			cnt_q   <= clear ? '0 : cnt_n;
			hit_q   <= clear ? 1'b0 : hit_n;
			slot_q  <= clear ? '0 : slot_n;
			err_q   <= clear ? ERR_OK : err_n;
		end
	end

	always_comb begin
		at_start  = (phase_q != PH_TAG) && (phase_q != PH_VALUE);
		eff_phase = at_start ? PH_TAG : phase_q;
		acc_e     = at_start ? '0 : acc_q;
		cnt_e     = at_start ? '0 : cnt_q;
		hit_e     = at_start ? 1'b0 : hit_q;
		slot_e    = at_start ? '0 : slot_q;
		err_e     = at_start ? ERR_OK : err_q;

		is_soh   = (byte_s1 == SOH_CHAR);
		is_sep   = (byte_s1 == SEP_CHAR);
		is_digit = (byte_s1 >= DIGIT0) && (byte_s1 <= DIGIT0 + 8'd9);

		// tag digit: acc * 10 + digit, clamped
		prod = (MUL_W'(acc_e) << 3) + (MUL_W'(acc_e) << 1)
			+ MUL_W'(byte_s1[3:0]);
		acc_t = acc_e;
		err_t = err_e;
		if (!is_sep) begin
			if (is_digit) begin
				if (prod > MUL_W'(TAG_MAX)) begin
					acc_t = TAG_MAX;
					if (err_t == ERR_OK) err_t = ERR_TAG_OVF;
				end else begin
					acc_t = prod[TAG_W-1:0];
				end
			end else if (err_t == ERR_OK) begin
				err_t = ERR_NONDIGIT;
			end
			if (last_s1 && err_t == ERR_OK) err_t = ERR_IN_TAG;
		end

		// lowest enabled slot wins
		m_hit  = 1'b0;
		m_slot = '0;
		for (int i = TAG_SLOTS - 1; i >= 0; i--) begin
			if (slot_en[i] && slot_tag[i] == acc_t) begin
				m_hit  = 1'b1;
				m_slot = SLOT_W'(i);
			end
		end
		if (err_t == ERR_NONDIGIT || err_t == ERR_TAG_OVF) begin
			m_hit  = 1'b0;
			m_slot = '0;
		end

		phase_n = eff_phase;
		acc_n   = acc_e;
		cnt_n   = cnt_e;
		hit_n   = hit_e;
		slot_n  = slot_e;
		err_n   = err_e;
		clear   = 1'b0;
		push_c  = '0;

		unique case (eff_phase)
			PH_TAG: begin
				if (at_start && is_soh) begin
					// leading SOH: drop it
					clear   = 1'b1;
					phase_n = last_s1 ? PH_START : PH_TAG;
				end else begin
					acc_n = acc_t;
					err_n = err_t;
					if (is_sep || last_s1) begin
						hit_n  = m_hit;
						slot_n = m_slot;
					end
					if (is_sep && !last_s1) begin
						phase_n = PH_VALUE;
						cnt_n   = '0;
					end
					if (last_s1) begin
						if (pass_mode || m_hit) begin
							push_c.n  = 2'd1;
							push_c.r0 = mk_res(KIND_END, acc_t, '0, '0, m_hit, m_slot,
								err_t, 1'b1);
						end
						clear   = 1'b1;
						phase_n = PH_START;
					end
				end
			end
			PH_VALUE: begin
				if (!is_soh) begin
					if (cnt_e >= CNT_W'(MAX_VALUE_LEN)) begin
						if (err_n == ERR_OK) err_n = ERR_LEN_SAT;
					end else begin
						cnt_n = cnt_e + 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		cnt_ext = EXT_W'(cnt_n);
		len_n   = (cnt_ext > EXT_W'(255)) ? 8'hFF : cnt_ext[LEN_W-1:0];

		if (eff_phase == PH_VALUE) begin
			if (is_soh) begin
				if (pass_mode || hit_e) begin
					push_c.n  = 2'd1;
					push_c.r0 = mk_res(KIND_END, acc_e, '0, len_n, hit_e, slot_e, err_n,
						last_s1);
				end
				clear   = 1'b1;
				phase_n = last_s1 ? PH_START : PH_TAG;
			end else begin
				if (pass_mode || hit_e) begin
					push_c.r0 = mk_res(KIND_VALUE, acc_e, byte_s1, len_n, hit_e, slot_e,
						err_n, 1'b0);
					push_c.r1 = mk_res(KIND_END, acc_e, '0, len_n, hit_e, slot_e,
						err_n, 1'b1);
					push_c.n  = last_s1 ? 2'd2 : 2'd1;
				end
				if (last_s1) begin
					clear   = 1'b1;
					phase_n = PH_START;
				end
			end
		end

		// mark the final result of this byte
		push_c.r0.last = (push_c.n == 2'd1);
		push_c.r1.last = 1'b1;
		if (!adv) push_c.n = 2'd0;
	end

	assign push = push_c;

endmodule

`default_nettype wire

/* rtl/fxtok_outq.sv */
// ----------------------------------------------------------------------------
// fxtok_outq
// Four-entry result queue taking up to two results a cycle, giving one while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module fxtok_outq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fxtok_pkg::push_t  push,
	output logic                   room,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output fxtok_pkg::res_t        out_res
);
	import fxtok_pkg::*;

	res_t                entry [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] wr_ptr_q;
	logic [OQ_PTR_W-1:0] rd_ptr_q;
	logic [OQ_CNT_W-1:0] count_q;
	logic                pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_res   = entry[rd_ptr_q];
	// keep space for a two-result byte
	assign room      = (count_q <= OQ_CNT_W'(OQ_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			entry[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			entry[wr_ptr_q + 1'b1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OQ_PTR_W'(push.n);
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + OQ_CNT_W'(push.n) - OQ_CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

/* rtl/fix_tag_value_tokenizer.sv */
// ----------------------------------------------------------------------------
// fix_tag_value_tokenizer
// FIX tag=value tokenizer: one message byte in, value bytes and field summaries out.
// ----------------------------------------------------------------------------
// Takes one FIX message byte per cycle on the slave stream and splits the
// message into fields. A single SOH at message start is dropped; the bytes up
// to '=' form a decimal tag (clamped at 999999), the bytes up to the next SOH
// are the value. The tag is compared with the enabled tag slots (lowest slot
// wins). In filter mode (pass_mode 0) only matching fields come out; in pass
// mode every field comes out with tag_registered showing the match. Each value
// byte gives one result of kind 0 and each field end one summary of kind 1
// carrying length and error code. A byte flagged tlast closes the open field
// even without a trailing SOH. Rate: one byte per cycle while the result
// queue has room. A byte is held in the input register, then its results
// (none, one or two) enter a four-entry result queue, which shows them at
// the output. The input side stalls only while the queue holds more than two
// results; a byte that closes a field with a value byte needs two output
// transactions, which the queue absorbs. Configuration writes are taken in
// every cycle and belong only to idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fix_tag_value_tokenizer_defines.svh"

module fix_tag_value_tokenizer #(
	parameter int TAG_SLOTS     = 6,
	parameter int MAX_VALUE_LEN = 255
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration write channel
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [fxtok_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fxtok_pkg::CFG_DATA_W-1:0] cfg_data,
	// message bytes
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [7:0]                       s_axis_tdata,  // [7:0] data_byte
	input  wire logic                             s_axis_tlast,  // last_in_message
	// results
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// [19:0] field_tag, [27:20] value_byte, [35:28] value_length,
	// [36] tag_registered, [39:37] matched_slot, [42:40] error_code, [47:43] zero
	output logic [47:0]                           m_axis_tdata,
	// [0] result_kind, [1] message_end
	output logic [1:0]                            m_axis_tuser,
	output logic                                  m_axis_tlast   // last_of_run
);
	import fxtok_pkg::*;

	logic             pass_mode;
	logic [TAG_W-1:0] slot_tag [TAG_SLOTS];
	logic [TAG_SLOTS-1:0] slot_en;
	logic             room;
	push_t            push;
	res_t             out_res;

	// registers accept a write in every cycle
	assign cfg_ready = 1'b1;

	fxtok_cfg #(
		.TAG_SLOTS (TAG_SLOTS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (cfg_valid),
		.wr_index  (cfg_index),
		.wr_data   (cfg_data),
		.pass_mode (pass_mode),
		.slot_tag  (slot_tag),
		.slot_en   (slot_en)
	);

	// register the byte, parse it and hand its results on
	fxtok_parse #(
		.TAG_SLOTS     (TAG_SLOTS),
		.MAX_VALUE_LEN (MAX_VALUE_LEN)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.pass_mode (pass_mode),
		.slot_tag  (slot_tag),
		.slot_en   (slot_en),
		.room      (room),
		.push      (push)
	);

	// hold results until the downstream side takes them
	fxtok_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	// pack the result fields, lowest field first
	assign m_axis_tdata = {5'd0, out_res.err, out_res.slot, out_res.registered,
		out_res.vlen, out_res.vbyte, out_res.tag};
	assign m_axis_tuser = {out_res.msg_end, out_res.kind};
	assign m_axis_tlast = out_res.last;

	// a summary closing the message is always the last result of its byte
	`FXTOK_ASSERT_IMPLY(a_msg_end_is_last, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast)
	// a value byte always reports a nonzero length
	`FXTOK_ASSERT_IMPLY(a_value_len_nonzero, m_axis_tvalid && (m_axis_tuser[0] == KIND_VALUE), m_axis_tdata[35:28] != 8'd0)
	// an unmatched field reports slot zero
	`FXTOK_ASSERT_IMPLY(a_unreg_slot_zero, m_axis_tvalid && !m_axis_tdata[36], m_axis_tdata[39:37] == 3'd0)
	// a byte with two results is followed by a valid output
	`FXTOK_ASSERT_NEXT(a_pair_completes, push.n == 2'd2, m_axis_tvalid)

endmodule

`default_nettype wire
